### hdl/egb_pkg.sv
// egb_pkg: types, codes and constants shared by the epsilon-greedy bandit selector
// depends on nothing; imported by the top level and the weight store
`default_nettype none

package egb_pkg;

   typedef logic signed [20:0] weight_type;

   localparam weight_type WEIGHT_RESET = 21'sd13107;
   localparam int         W_MAX        = 1048575;
   localparam int         W_MIN        = -1048576;

   // item kinds carried in req_tuser
   localparam logic [1:0] MODE_SELECT = 2'd0;
   localparam logic [1:0] MODE_UPDATE = 2'd1;
   localparam logic [1:0] MODE_RESET  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_EPSILON        = 2'd0;
   localparam logic [1:0] CSR_NUM_ACTIONS    = 2'd1;
   localparam logic [1:0] CSR_DEFAULT_WEIGHT = 2'd2;

   localparam logic [16:0] EPSILON_RESET     = 17'd0;
   localparam logic [4:0]  NUM_ACTIONS_RESET = 5'd16;

   // ceil(2^28 / 10): exact quotient for dividends below 2^24
   localparam logic [31:0] RECIP_10    = 32'd26843546;
   localparam int          RECIP_SHIFT = 28;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } store_cmd_type;

endpackage

`default_nettype wire

### hdl/epsilon_greedy_bandit_selector_core.sv
// epsilon-greedy bandit selector: one item at a time, req_tready high only when idle
// select: four multiplies, a compare and, if greedy, a scan of n weights (one weight read
// per cycle); update: read, calc, mul, write; unused-action update, reset, mode 3: no steps
// the four multiplies of the exploration test share one 32x32 multiplier; an item
// is accepted again in the cycle after its result is loaded into the output register
// synchronous reset; weights read as 0.2 through valid bits, no clearing pass
`default_nettype none

module epsilon_greedy_bandit_selector_core #(
   parameter int MAX_ACTIONS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] rand_fraction, [19:16] rand_action, [23:20] action, [44:24] score, zero above
   input  wire logic [47:0] req_tdata,
   // [1:0] mode
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] selected_action, zero above
   output logic      [7:0]  rsp_tdata,
   // [0] explored
   output logic      [0:0]  rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [20:0] csr_data
);

   import egb_pkg::*;

   localparam int IDX_W = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_ACTIONS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_RR, ST_MUL_RRC, ST_MUL_EN, ST_MUL_ENE, ST_CMP, ST_SCAN,
      ST_UPD_RD, ST_UPD_CALC, ST_UPD_MUL, ST_UPD_FIX, ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [16:0]      eps_ff, eps_in;
   logic [4:0]       nact_ff, nact_in;
   weight_type       dflt_ff, dflt_in;
   logic [31:0]      count_ff, count_in;
   logic [15:0]      r_ff, r_in;
   logic [3:0]       ra_ff, ra_in;
   logic [3:0]       act_ff, act_in;
   weight_type       score_ff, score_in;
   logic [63:0]      lhs_ff, lhs_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   weight_type       best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [23:0]      mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic [3:0]       sel_ff, sel_in;
   logic             expl_ff, expl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_sel_ff, rsp_sel_in;
   logic             rsp_expl_ff, rsp_expl_in;

   logic [CNT_W-1:0] n_eff;
   logic             req_accept;
   logic [31:0]      mul_a, mul_b;
   logic             mul_en;
   logic [63:0]      prod;
   store_cmd_type    cmd;
   logic [IDX_W-1:0] st_addr;
   weight_type       st_wdata;
   weight_type       rd_data;

   egb_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   egb_weight_store #(.DEPTH(MAX_ACTIONS)) u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .addr       (st_addr),
      .wr_data    (st_wdata),
      .fill_value (dflt_ff),
      .rd_data    (rd_data)
   );

   // actions in use, clamped to 1..MAX_ACTIONS
   always_comb begin
      if (nact_ff == 5'd0) begin
         n_eff = CNT_W'(1);
      end else if (32'(nact_ff) > 32'(MAX_ACTIONS)) begin
         n_eff = CNT_W'(MAX_ACTIONS);
      end else begin
         n_eff = CNT_W'(nact_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      logic               take;
      logic signed [25:0] x;
      logic        [25:0] ax;
      logic        [20:0] q;
      logic signed [21:0] qs;

      state_in     = state_ff;
      eps_in       = eps_ff;
      nact_in      = nact_ff;
      dflt_in      = dflt_ff;
      count_in     = count_ff;
      r_in         = r_ff;
      ra_in        = ra_ff;
      act_in       = act_ff;
      score_in     = score_ff;
      lhs_in       = lhs_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sel_in       = sel_ff;
      expl_in      = expl_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_expl_in  = rsp_expl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_a        = '0;
      mul_b        = '0;
      mul_en       = 1'b0;
      cmd          = '0;
      st_addr      = '0;
      st_wdata     = '0;
      take         = 1'b0;
      x            = '0;
      ax           = '0;
      q            = '0;
      qs           = '0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_EPSILON:        eps_in  = csr_data[16:0];
            CSR_NUM_ACTIONS:    nact_in = csr_data[4:0];
            CSR_DEFAULT_WEIGHT: dflt_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               r_in     = req_tdata[15:0];
               ra_in    = req_tdata[19:16];
               act_in   = req_tdata[23:20];
               score_in = req_tdata[44:24];
               sel_in   = 4'd0;
               expl_in  = 1'b0;
               unique case (req_tuser)
                  MODE_SELECT: begin
                     if (count_ff != 32'hFFFF_FFFF) begin
                        count_in = count_ff + 32'd1;
                     end
                     state_in = ST_MUL_RR;
                  end
                  MODE_UPDATE: begin
                     sel_in = req_tdata[23:20];
                     if (32'(req_tdata[23:20]) < 32'(n_eff)) begin
                        state_in = ST_UPD_RD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  MODE_RESET: begin
                     cmd.clear = 1'b1;
                     count_in  = '0;
                     state_in  = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MUL_RR: begin
            mul_en   = 1'b1;
            mul_a    = 32'(r_ff);
            mul_b    = 32'(r_ff);
            state_in = ST_MUL_RRC;
         end
         ST_MUL_RRC: begin
            mul_en   = 1'b1;
            mul_a    = prod[31:0];
            mul_b    = count_ff;
            state_in = ST_MUL_EN;
         end
         ST_MUL_EN: begin
            lhs_in   = prod;
            mul_en   = 1'b1;
            mul_a    = 32'(eps_ff);
            mul_b    = 32'(n_eff);
            state_in = ST_MUL_ENE;
         end
         ST_MUL_ENE: begin
            mul_en   = 1'b1;
            mul_a    = prod[31:0];
            mul_b    = 32'(eps_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (lhs_ff < prod) begin
               expl_in = 1'b1;
               if (32'(ra_ff) > 32'(n_eff) - 32'd1) begin
                  sel_in = 4'(n_eff - CNT_W'(1));
               end else begin
                  sel_in = ra_ff;
               end
               state_in = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               st_addr    = '0;
               rd_idx_in  = CNT_W'(1);
               cmp_idx_in = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // first strictly larger weight wins, so ties keep the lower index
            take = (cmp_idx_ff == '0) || (rd_data > best_ff);
            if (take) begin
               best_in     = rd_data;
               best_idx_in = cmp_idx_ff;
            end
            cmd.rd_en = (rd_idx_ff < n_eff);
            st_addr   = rd_idx_ff[IDX_W-1:0];
            rd_idx_in = rd_idx_ff + CNT_W'(1);
            if (CNT_W'(cmp_idx_ff) == n_eff - CNT_W'(1)) begin
               sel_in   = 4'(best_idx_in);
               state_in = ST_DONE;
            end else begin
               cmp_idx_in = cmp_idx_ff + IDX_W'(1);
            end
         end
         ST_UPD_RD: begin
            cmd.rd_en = 1'b1;
            st_addr   = IDX_W'(act_ff);
            state_in  = ST_UPD_CALC;
         end
         ST_UPD_CALC: begin
            // 9*w + score, then magnitude plus half the divisor
            x        = (26'(rd_data) <<< 3) + 26'(rd_data) + 26'(score_ff);
            neg_in   = x[25];
            ax       = x[25] ? 26'(-x) : 26'(x);
            mag_in   = 24'(ax + 26'd5);
            state_in = ST_UPD_MUL;
         end
         ST_UPD_MUL: begin
            mul_en   = 1'b1;
            mul_a    = 32'(mag_ff);
            mul_b    = RECIP_10;
            state_in = ST_UPD_FIX;
         end
         ST_UPD_FIX: begin
            q  = prod[RECIP_SHIFT+20:RECIP_SHIFT];
            qs = neg_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (qs > 22'(W_MAX)) begin
               st_wdata = 21'(W_MAX);
            end else if (qs < 22'(W_MIN)) begin
               st_wdata = 21'(W_MIN);
            end else begin
               st_wdata = 21'(qs);
            end
            cmd.wr_en = 1'b1;
            st_addr   = IDX_W'(act_ff);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_sel_in   = sel_ff;
               rsp_expl_in  = expl_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eps_ff       <= EPSILON_RESET;
         nact_ff      <= NUM_ACTIONS_RESET;
         dflt_ff      <= WEIGHT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eps_ff       <= eps_in;
         nact_ff      <= nact_in;
         dflt_ff      <= dflt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff        <= r_in;
      ra_ff       <= ra_in;
      act_ff      <= act_in;
      score_ff    <= score_in;
      lhs_ff      <= lhs_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      sel_ff      <= sel_in;
      expl_ff     <= expl_in;
      rsp_sel_ff  <= rsp_sel_in;
      rsp_expl_ff <= rsp_expl_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_sel_ff};
   assign rsp_tuser  = rsp_expl_ff;

endmodule

`default_nettype wire

### hdl/egb_mul.sv
// egb_mul: shared 32 x 32 unsigned multiplier with a registered product
// no package dependency; used by the top level sequencer
`default_nettype none

module egb_mul (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [63:0] prod
);

   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 64'(a) * 64'(b);
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### hdl/egb_weight_store.sv
// egb_weight_store: action weight memory with per-entry valid bits and a fill value
// depends on egb_pkg; an entry not written since the last clear reads as the fill value
`default_nettype none

module egb_weight_store #(
   parameter  int DEPTH = 16,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire egb_pkg::store_cmd_type cmd,
   input  wire logic [IDX_W-1:0]      addr,
   input  wire egb_pkg::weight_type   wr_data,
   input  wire egb_pkg::weight_type   fill_value,
   output egb_pkg::weight_type        rd_data
);

   import egb_pkg::*;

   weight_type       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   weight_type       fill_ff;
   weight_type       rd_q_ff;
   logic             rd_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= WEIGHT_RESET;
      end else if (cmd.clear) begin
         valid_ff <= '0;
         fill_ff  <= fill_value;
      end else if (cmd.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff   <= mem[addr];
         rd_hit_ff <= valid_ff[addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_q_ff : fill_ff;

endmodule

`default_nettype wire

### hdl/egb_checker.sv
// egb_checker: port-level assertions for the bandit selector core
// no package dependency; attached to the top level by the bind below
`default_nettype none

module egb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [0:0] rsp_tuser
);

   // after reset the block is idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("not idle after reset");

   // one item at a time: ready drops right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready held after accept");

   // no result appears in the cycle right after an accept
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind epsilon_greedy_bandit_selector_core egb_checker u_checker (.*);

`default_nettype wire
